// ----- rtl/core/spsa_pkg.sv -----
// ----------------------------------------------------------------------------
// spsa_pkg
// Shared field widths, request and status codes and slot word layout for the
// slotted page slot allocator.
// ----------------------------------------------------------------------------
package spsa_pkg;

    // request payload widths
    localparam int OPCODE_W = 2;
    localparam int SIZE_W   = 24;
    localparam int INDEX_W  = 8;
    localparam int WORD_W   = 64;

    // result payload widths
    localparam int STATUS_W = 2;
    localparam int SLOT_W   = 8;
    localparam int OFFSET_W = 24;
    localparam int USED_W   = 9;
    localparam int PAGE_W   = 48;

    // configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 48;
    localparam logic [CFG_IDX_W-1:0] CFG_PAGE_BYTES  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_PAGE_NUMBER = 1'b1;

    // request codes
    localparam logic [OPCODE_W-1:0] OP_ADD   = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_READ  = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_WRITE = 2'd2;

    // status codes
    localparam logic [STATUS_W-1:0] STAT_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_NO_SPACE = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_DIR_FULL = 2'd2;

    // slot word layout
    localparam int          TAG_LSB    = 56;
    localparam int          OFS_LSB    = 24;
    localparam logic [7:0]  SLOT_TAG   = 8'hFF;
    localparam int          SLOT_BYTES = 8;

    // page length after reset
    localparam logic [SIZE_W-1:0] PAGE_BYTES_RST = 24'd4096;

endpackage

// ----- rtl/core/spsa_req_if.sv -----
// ----------------------------------------------------------------------------
// spsa_req_if
// Request channel of the slot allocator: valid, ready and request payload.
// ----------------------------------------------------------------------------
interface spsa_req_if;

    logic                          valid;
    logic                          ready;
    logic [spsa_pkg::OPCODE_W-1:0] opcode;
    logic [spsa_pkg::SIZE_W-1:0]   rec_bytes;
    logic [spsa_pkg::INDEX_W-1:0]  slot_index;
    logic [spsa_pkg::WORD_W-1:0]   slot_value;

    modport source (
        output valid, opcode, rec_bytes, slot_index, slot_value,
        input  ready
    );

    modport sink (
        input  valid, opcode, rec_bytes, slot_index, slot_value,
        output ready
    );

endinterface

// ----- rtl/core/spsa_rsp_if.sv -----
// ----------------------------------------------------------------------------
// spsa_rsp_if
// Result channel of the slot allocator: valid, ready and result payload.
// ----------------------------------------------------------------------------
interface spsa_rsp_if;

    logic                          valid;
    logic                          ready;
    logic [spsa_pkg::STATUS_W-1:0] status;
    logic [spsa_pkg::SLOT_W-1:0]   granted_slot;
    logic [spsa_pkg::WORD_W-1:0]   slot_word;
    logic [spsa_pkg::OFFSET_W-1:0] record_offset;
    logic [spsa_pkg::SIZE_W-1:0]   free_bytes;
    logic [spsa_pkg::USED_W-1:0]   slots_used;
    logic [spsa_pkg::PAGE_W-1:0]   record_page;

    modport source (
        output valid, status, granted_slot, slot_word, record_offset,
               free_bytes, slots_used, record_page,
        input  ready
    );

    modport sink (
        input  valid, status, granted_slot, slot_word, record_offset,
               free_bytes, slots_used, record_page,
        output ready
    );

endinterface

// ----- rtl/core/spsa_ram.sv -----
// ----------------------------------------------------------------------------
// spsa_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module spsa_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port, holds its data between reads
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/core/slotted_page_slot_allocator_core.sv -----
// ----------------------------------------------------------------------------
// slotted_page_slot_allocator_core
// Slotted page manager: carves records from the page end, keeps the slot
// directory in a RAM and finds the first zero slot with a flag scan.
// ----------------------------------------------------------------------------
//  channel   dir  handshake          contents
//  i_req     in   valid / ready      opcode, rec_bytes, slot_index, slot_value
//  o_rsp     out  valid / ready      status, slot, word, offset, free, used, page
//  i_cfg_*   in   write enable only  page length (index 0), page_number (index 1)
//
//  One request at a time. From accept to result valid: a write, a refused
//  add and an unknown code pass S_EXEC and S_RESP, a read adds S_RDATA (one
//  RAM read), a granted add adds the zero scan in S_SCAN, 16 flags a cycle,
//  stopping at the first zero slot. S_RESP holds until the output is free.
//  Reset and a page length write clear all slot flags together; an entry
//  with its flag clear reads as zero, so the RAM needs no clearing pass.
//  The result sits in an output register; a new request is taken while it
//  waits, and the next result waits in turn until it is taken.
// ----------------------------------------------------------------------------
module slotted_page_slot_allocator_core #(
    parameter int MAX_SLOTS    = 256,
    parameter int HEADER_BYTES = 48
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [spsa_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [spsa_pkg::CFG_DATA_W-1:0] i_cfg_data,
    spsa_req_if.sink                        i_req,
    spsa_rsp_if.source                      o_rsp
);

    localparam int IDX_W = $clog2(MAX_SLOTS);
    localparam int CNT_W = $clog2(MAX_SLOTS + 1);
    localparam int GRP   = (MAX_SLOTS < 16) ? MAX_SLOTS : 16;
    localparam int NGRP  = (MAX_SLOTS + GRP - 1) / GRP;
    localparam int PAD   = NGRP * GRP;
    localparam int GW    = (NGRP > 1) ? $clog2(NGRP) : 1;

    localparam logic [spsa_pkg::SIZE_W-1:0] HDR = 24'(HEADER_BYTES);
    localparam logic [spsa_pkg::SIZE_W-1:0] RST_FREE =
        (4096 > HEADER_BYTES) ? 24'(4096 - HEADER_BYTES) : 24'd0;
    localparam logic [spsa_pkg::SIZE_W:0] SLOT_GROWTH = 25'(spsa_pkg::SLOT_BYTES);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_SCAN,
        S_RDATA,
        S_RESP
    } t_state;

    t_state r_state;

    // configuration and page state
    logic [spsa_pkg::PAGE_W-1:0]   r_page_num;
    logic [spsa_pkg::SIZE_W-1:0]   r_data_start;
    logic [spsa_pkg::SIZE_W-1:0]   r_free;
    logic [CNT_W-1:0]              r_total;
    logic [CNT_W-1:0]              r_first_free;
    logic [MAX_SLOTS-1:0]          r_nz;

    // held request
    logic [spsa_pkg::OPCODE_W-1:0] r_op;
    logic [spsa_pkg::SIZE_W-1:0]   r_size;
    logic [spsa_pkg::INDEX_W-1:0]  r_idx;
    logic [spsa_pkg::WORD_W-1:0]   r_val;

    // pending result
    logic [spsa_pkg::STATUS_W-1:0] r_res_status;
    logic [spsa_pkg::SLOT_W-1:0]   r_res_slot;
    logic [spsa_pkg::WORD_W-1:0]   r_res_word;
    logic [spsa_pkg::OFFSET_W-1:0] r_res_offset;
    logic [spsa_pkg::PAGE_W-1:0]   r_res_page;
    logic                          r_rd_nz;
    logic [GW-1:0]                 r_grp;

    // output register
    logic                          r_out_valid;
    logic [spsa_pkg::STATUS_W-1:0] r_out_status;
    logic [spsa_pkg::SLOT_W-1:0]   r_out_slot;
    logic [spsa_pkg::WORD_W-1:0]   r_out_word;
    logic [spsa_pkg::OFFSET_W-1:0] r_out_offset;
    logic [spsa_pkg::SIZE_W-1:0]   r_out_free;
    logic [spsa_pkg::USED_W-1:0]   r_out_used;
    logic [spsa_pkg::PAGE_W-1:0]   r_out_page;

    // combinational
    logic                          w_append;
    logic [spsa_pkg::SIZE_W:0]     w_need;
    logic                          w_dir_full;
    logic                          w_no_space;
    logic                          w_grant;
    logic [spsa_pkg::STATUS_W-1:0] w_add_status;
    logic [IDX_W-1:0]              w_slot;
    logic [IDX_W-1:0]              w_idx;
    logic                          w_idx_ok;
    logic [spsa_pkg::SIZE_W-1:0]   n_data_start;
    logic [CNT_W-1:0]              n_total;
    logic [spsa_pkg::SIZE_W-1:0]   w_used;
    logic [spsa_pkg::SIZE_W-1:0]   n_free;
    logic [spsa_pkg::SIZE_W-1:0]   w_cfg_free;
    logic [spsa_pkg::WORD_W-1:0]   w_new_word;
    logic [PAD-1:0]                w_pad;
    logic [GRP-1:0]                w_grp_bits;
    logic                          w_scan_hit;
    logic [CNT_W-1:0]              w_scan_pos;
    logic                          w_scan_last;
    logic                          w_out_free;
    logic                          w_out_load;
    logic                          w_mem_we;
    logic [IDX_W-1:0]              w_mem_waddr;
    logic [spsa_pkg::WORD_W-1:0]   w_mem_wdata;
    logic                          w_mem_re;
    logic [spsa_pkg::WORD_W-1:0]   w_mem_rdata;

    // add decision and new slot word
    assign w_append     = (r_first_free >= r_total);
    assign w_need       = {1'b0, r_size} + (w_append ? SLOT_GROWTH : '0);
    assign w_dir_full   = w_append && (r_total == CNT_W'(MAX_SLOTS));
    assign w_no_space   = (w_need > {1'b0, r_free});
    assign w_grant      = (r_op == spsa_pkg::OP_ADD) && !w_dir_full && !w_no_space;
    assign w_add_status = w_dir_full ? spsa_pkg::STAT_DIR_FULL
                        : w_no_space ? spsa_pkg::STAT_NO_SPACE : spsa_pkg::STAT_OK;
    assign w_slot       = w_append ? r_total[IDX_W-1:0] : r_first_free[IDX_W-1:0];
    assign n_data_start = r_data_start - r_size;
    assign n_total      = w_append ? r_total + 1'b1 : r_total;
    assign w_new_word   = {spsa_pkg::SLOT_TAG, 8'h00, n_data_start, r_size};

    // read and write index range
    assign w_idx    = IDX_W'(r_idx);
    assign w_idx_ok = (32'(r_idx) < 32'(MAX_SLOTS));

    // free space from the registered pointer and count
    assign w_used = 24'({r_total, 3'b000}) + HDR;
    assign n_free = (r_data_start > w_used) ? r_data_start - w_used : '0;

    // free space of a fresh page on a page length write
    assign w_cfg_free = (i_cfg_data[spsa_pkg::SIZE_W-1:0] > HDR)
                      ? i_cfg_data[spsa_pkg::SIZE_W-1:0] - HDR : '0;

    // zero slot scan, one group of flags a cycle
    always_comb begin
        logic [31:0] v_pos;
        v_pos = '0;
        w_pad = '1;
        w_pad[MAX_SLOTS-1:0] = r_nz;
        w_grp_bits = w_pad[32'(r_grp) * GRP +: GRP];
        w_scan_hit = 1'b0;
        w_scan_pos = '0;
        for (int j = GRP - 1; j >= 0; j--) begin
            v_pos = 32'(r_grp) * 32'(GRP) + 32'(j);
            if (!w_grp_bits[j] && (v_pos < 32'(r_total))) begin
                w_scan_hit = 1'b1;
                w_scan_pos = CNT_W'(v_pos);
            end
        end
        w_scan_last = ((32'(r_grp) + 32'd1) * 32'(GRP) >= 32'(r_total))
                   || (r_grp == GW'(NGRP - 1));
    end

    // slot RAM port control
    always_comb begin
        w_mem_we    = 1'b0;
        w_mem_waddr = w_slot;
        w_mem_wdata = w_new_word;
        w_mem_re    = 1'b0;
        if (r_state == S_EXEC) begin
            unique case (r_op)
                spsa_pkg::OP_ADD: begin
                    w_mem_we = !w_dir_full && !w_no_space;
                end
                spsa_pkg::OP_WRITE: begin
                    w_mem_we    = w_idx_ok;
                    w_mem_waddr = w_idx;
                    w_mem_wdata = r_val;
                end
                spsa_pkg::OP_READ: begin
                    w_mem_re = 1'b1;
                end
                default: begin
                    w_mem_we = 1'b0;
                end
            endcase
        end
    end

    spsa_ram #(
        .WIDTH (spsa_pkg::WORD_W),
        .DEPTH (MAX_SLOTS)
    ) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (w_mem_we),
        .i_waddr (w_mem_waddr),
        .i_wdata (w_mem_wdata),
        .i_re    (w_mem_re),
        .i_raddr (w_idx),
        .o_rdata (w_mem_rdata)
    );

    assign w_out_free = !r_out_valid || o_rsp.ready;
    assign w_out_load = (r_state == S_RESP) && w_out_free;

    // request sequencer, page state and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_page_num   <= '0;
            r_data_start <= spsa_pkg::PAGE_BYTES_RST;
            r_free       <= RST_FREE;
            r_total      <= '0;
            r_first_free <= '0;
            r_nz         <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            // result loaded, or taken downstream
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end

            // configuration writes, to be made only while idle; the block does not enforce it
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    spsa_pkg::CFG_PAGE_BYTES: begin
                        r_data_start <= i_cfg_data[spsa_pkg::SIZE_W-1:0];
                        r_free       <= w_cfg_free;
                        r_total      <= '0;
                        r_first_free <= '0;
                        r_nz         <= '0;
                    end
                    spsa_pkg::CFG_PAGE_NUMBER: begin
                        r_page_num <= i_cfg_data[spsa_pkg::PAGE_W-1:0];
                    end
                endcase
            end

            unique case (r_state)
                S_IDLE: begin
                    if (i_req.valid) begin
                        r_op    <= i_req.opcode;
                        r_size  <= i_req.rec_bytes;
                        r_idx   <= i_req.slot_index;
                        r_val   <= i_req.slot_value;
                        r_state <= S_EXEC;
                    end
                end

                S_EXEC: begin
                    r_res_status <= (r_op == spsa_pkg::OP_ADD) ? w_add_status
                                                               : spsa_pkg::STAT_OK;
                    r_res_slot   <= w_grant ? spsa_pkg::SLOT_W'(w_slot) : '0;
                    r_res_word   <= w_grant ? w_new_word : '0;
                    r_res_offset <= w_grant ? n_data_start : '0;
                    r_res_page   <= w_grant ? r_page_num : '0;
                    if (w_grant) begin
                        r_data_start <= n_data_start;
                        r_total      <= n_total;
                        r_nz[w_slot] <= 1'b1;
                        r_grp        <= '0;
                        r_state      <= S_SCAN;
                    end else if (r_op == spsa_pkg::OP_READ) begin
                        r_rd_nz <= w_idx_ok && r_nz[w_idx];
                        r_state <= S_RDATA;
                    end else begin
                        // write keeps the zero flag in step; other codes change nothing
                        if ((r_op == spsa_pkg::OP_WRITE) && w_idx_ok) begin
                            r_nz[w_idx] <= |r_val;
                        end
                        r_state <= S_RESP;
                    end
                end

                S_SCAN: begin
                    // free space follows the new pointer and count
                    if (r_grp == '0) begin
                        r_free <= n_free;
                    end
                    if (w_scan_hit) begin
                        r_first_free <= w_scan_pos;
                        r_state      <= S_RESP;
                    end else if (w_scan_last) begin
                        r_first_free <= r_total;
                        r_state      <= S_RESP;
                    end else begin
                        r_grp <= r_grp + 1'b1;
                    end
                end

                S_RDATA: begin
                    r_res_word <= r_rd_nz ? w_mem_rdata : '0;
                    r_state    <= S_RESP;
                end

                S_RESP: begin
                    if (w_out_load) begin
                        r_out_status <= r_res_status;
                        r_out_slot   <= r_res_slot;
                        r_out_word   <= r_res_word;
                        r_out_offset <= r_res_offset;
                        r_out_free   <= r_free;
                        r_out_used   <= spsa_pkg::USED_W'(r_total);
                        r_out_page   <= r_res_page;
                        r_state      <= S_IDLE;
                    end
                end
            endcase
        end
    end

    // channel ports
    assign i_req.ready         = (r_state == S_IDLE);
    assign o_rsp.valid         = r_out_valid;
    assign o_rsp.status        = r_out_status;
    assign o_rsp.granted_slot  = r_out_slot;
    assign o_rsp.slot_word     = r_out_word;
    assign o_rsp.record_offset = r_out_offset;
    assign o_rsp.free_bytes    = r_out_free;
    assign o_rsp.slots_used    = r_out_used;
    assign o_rsp.record_page   = r_out_page;

endmodule
